@@ rtl/fmhp_pkg.sv @@
// ----------------------------------------------------------------------------
// fmhp_pkg
// shared types, codes and constants of the flac metadata header parser
// ----------------------------------------------------------------------------
package fmhp_pkg;

  typedef enum logic [1:0] {
    EvBad   = 2'd0,
    EvHdr   = 2'd1,
    EvEnd   = 2'd2,
    EvTrunc = 2'd3
  } event_e;

  localparam int unsigned MinInfoLen = 34;
  localparam int unsigned InfoFirst  = 10;
  localparam int unsigned InfoLast   = 17;

  // results caused by one input byte: one or two, sharing the block fields
  typedef struct packed {
    logic        two;
    event_e      ev0;
    event_e      ev1;
    logic [6:0]  block_type;
    logic        is_last;
    logic [23:0] block_length;
    logic        info_valid;
    logic [19:0] sample_rate;
    logic [3:0]  channel_count;
    logic [5:0]  sample_bits;
    logic [35:0] total_samples;
  } rec_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = 8'h66;
      2'd1:    m = 8'h4C;
      2'd2:    m = 8'h61;
      default: m = 8'h43;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/flac_metadata_header_parser.sv @@
// ----------------------------------------------------------------------------
// flac_metadata_header_parser
// byte-serial fLaC magic check and metadata block header walker
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the queue has room. Each byte is
// parsed in the cycle it is accepted and its results (one or two) are written
// as one record into a two-entry output queue; a byte without results writes
// nothing. A byte with two results presents them in turn from that record.
// The sustained rate is one byte per cycle while bytes cause at most one
// result and the output side takes every result; two-result bytes and output
// stalls fill the queue, and then the output handshake sets the byte rate.
module flac_metadata_header_parser
  import fmhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [6:0]  block_type_o,
  output logic        is_last_block_o,
  output logic [23:0] block_length_o,
  output logic        stream_info_valid_o,
  output logic [19:0] sample_rate_o,
  output logic [3:0]  channel_count_o,
  output logic [5:0]  sample_bits_o,
  output logic [35:0] total_samples_o,
  output logic        last_of_run_o
);

  localparam logic [2:0] PhMagic  = 3'd0;
  localparam logic [2:0] PhHeader = 3'd1;
  localparam logic [2:0] PhBody   = 3'd2;
  localparam logic [2:0] PhTail   = 3'd3;
  localparam logic [2:0] PhBad    = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [23:0] pos_q, pos_d;
  logic [6:0]  type_q, type_d;
  logic        flag_q, flag_d;
  logic [23:0] len_q, len_d;
  logic [63:0] info_q, info_d;

  logic        in_fire, out_fire, push, pop;
  logic        have0, have1, with_block, info_v, blk_end;
  event_e      ev0, ev1;
  logic [31:0] word;
  rec_t        rec;

  rec_t        mem_q [2];
  logic        wr_ptr_q, rd_ptr_q, sub_q;
  logic [1:0]  count_q;
  rec_t        head;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    type_d     = type_q;
    flag_d     = flag_q;
    len_d      = len_q;
    info_d     = info_q;
    have0      = 1'b0;
    have1      = 1'b0;
    ev0        = EvBad;
    ev1        = EvBad;
    with_block = 1'b0;
    info_v     = 1'b0;
    blk_end    = 1'b0;
    unique case (phase_q)
      PhMagic: begin
        if (data_byte_i != magic_byte(pos_q[1:0])) begin
          have0   = 1'b1;
          phase_d = PhBad;
        end else if (pos_q[1:0] == 2'd3) begin
          phase_d = PhHeader;
          pos_d   = '0;
        end else begin
          pos_d = pos_q + 24'd1;
          have0 = end_of_file_i;
        end
      end
      PhHeader: begin
        with_block = 1'b1;
        if (pos_q == 24'd0) begin
          flag_d = data_byte_i[7];
          type_d = data_byte_i[6:0];
          len_d  = '0;
          info_d = '0;
        end else begin
          len_d = {len_q[15:0], data_byte_i};
        end
        if (pos_q >= 24'd3) begin
          have0 = 1'b1;
          ev0   = EvHdr;
          if (len_d == 24'd0) begin
            have1   = 1'b1;
            ev1     = EvEnd;
            blk_end = 1'b1;
          end else begin
            phase_d = PhBody;
            pos_d   = '0;
            have1   = end_of_file_i;
            ev1     = EvTrunc;
          end
        end else begin
          pos_d = pos_q + 24'd1;
          have0 = end_of_file_i;
          ev0   = EvTrunc;
        end
      end
      PhBody: begin
        with_block = 1'b1;
        if (pos_q >= 24'(InfoFirst) && pos_q <= 24'(InfoLast)) begin
          info_d = {info_q[55:0], data_byte_i};
        end
        if ({1'b0, pos_q} + 25'd1 >= {1'b0, len_q}) begin
          have0   = 1'b1;
          ev0     = EvEnd;
          info_v  = (type_q == 7'd0) && (len_q >= 24'(MinInfoLen));
          blk_end = 1'b1;
        end else begin
          pos_d = pos_q + 24'd1;
          have0 = end_of_file_i;
          ev0   = EvTrunc;
        end
      end
      default: begin
      end
    endcase
    if (blk_end) begin
      phase_d = flag_d ? PhTail : PhHeader;
      pos_d   = '0;
    end
  end

  // result record of the current byte
  always_comb begin
    word              = info_d[63:32];
    rec               = '0;
    rec.two           = have1;
    rec.ev0           = ev0;
    rec.ev1           = ev1;
    if (with_block) begin
      rec.block_type   = type_d;
      rec.is_last      = flag_d;
      rec.block_length = len_d;
    end
    if (info_v) begin
      rec.info_valid    = 1'b1;
      rec.sample_rate   = word[31:12];
      rec.channel_count = {1'b0, word[11:9]} + 4'd1;
      rec.sample_bits   = {1'b0, word[8:4]} + 6'd1;
      rec.total_samples = {word[3:0], info_d[31:0]};
    end
    if (with_block && end_of_file_i == 1'b0 && blk_end == 1'b0) begin
      rec.block_type   = type_d;
    end
  end

  // end of file rearms the parser after the byte's results are formed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMagic;
      pos_q   <= '0;
      type_q  <= '0;
      flag_q  <= 1'b0;
      len_q   <= '0;
      info_q  <= '0;
    end else if (in_fire) begin
      if (end_of_file_i) begin
        phase_q <= PhMagic;
        pos_q   <= '0;
        type_q  <= '0;
        flag_q  <= 1'b0;
        len_q   <= '0;
        info_q  <= '0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        type_q  <= type_d;
        flag_q  <= flag_d;
        len_q   <= len_d;
        info_q  <= info_d;
      end
    end
  end

  // output queue of byte records
  assign head          = mem_q[rd_ptr_q];
  assign in_ready_o    = (count_q != 2'd2);
  assign out_valid_o   = (count_q != 2'd0);
  assign last_of_run_o = ~head.two | sub_q;
  assign push          = in_fire & have0;
  assign pop           = out_fire & last_of_run_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      sub_q    <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        sub_q    <= 1'b0;
      end else if (out_fire) begin
        sub_q <= 1'b1;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign event_res_o         = sub_q ? head.ev1 : head.ev0;
  assign block_type_o        = head.block_type;
  assign is_last_block_o     = head.is_last;
  assign block_length_o      = head.block_length;
  assign stream_info_valid_o = head.info_valid;
  assign sample_rate_o       = head.sample_rate;
  assign channel_count_o     = head.channel_count;
  assign sample_bits_o       = head.sample_bits;
  assign total_samples_o     = head.total_samples;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output queue overflow");

  a_sub_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (out_valid_o && head.two))
    else $error("second result pending without a two-result record");

  a_eof_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_file_i) |=> (phase_q == PhMagic && pos_q == 24'd0))
    else $error("end of file did not rearm the parser");

  a_bad_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !end_of_file_i && phase_q == PhBad) |=> (phase_q == PhBad))
    else $error("left bad magic state before end of file");

endmodule

@@ test/flac_metadata_header_parser_tb.sv @@
// ----------------------------------------------------------------------------
// flac_metadata_header_parser_tb
// self-checking regression of the flac metadata header parser
// ----------------------------------------------------------------------------
// A short table of directed bytes covers bad and partial magic, magic-only
// files, extreme header values, an empty body, truncation and an end of file
// on a block boundary. Random files follow: mostly well-formed streams with
// stream info and other blocks, plus damaged magic, cut files, oversized
// lengths and raw noise. A behavioral parser in the testbench predicts every
// result, and each output transaction is compared field by field in order.
// Both handshakes stall at random in three mixes, the last without stalls.
// ----------------------------------------------------------------------------
module flac_metadata_header_parser_tb;
  import fmhp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {PhMagic, PhHeader, PhBody, PhTail, PhBad} parse_phase_e;
  typedef enum logic [1:0] {Predicted, Silent, BadMagic} row_check_e;

  typedef struct packed {
    event_e      ev;
    logic [6:0]  block_type;
    logic        last_blk;
    logic [23:0] len;
    logic        info_valid;
    logic [19:0] rate;
    logic [3:0]  chans;
    logic [5:0]  bits;
    logic [35:0] total;
    logic        last_of_run;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    row_check_e chk;
  } dir_row_t;

  localparam logic [7:0] FlacMagic [4] = '{8'h66, 8'h4C, 8'h61, 8'h43};

  localparam int NumDirRows = 29;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h00, 1'b0, BadMagic}, '{8'hFF, 1'b1, Silent},   '{8'h66, 1'b1, BadMagic},
    '{8'h66, 1'b0, Silent},   '{8'h4C, 1'b0, Silent},   '{8'h61, 1'b0, Silent},
    '{8'h43, 1'b1, Silent},
    '{8'h66, 1'b0, Silent},   '{8'h4C, 1'b0, Silent},   '{8'h61, 1'b0, Silent},
    '{8'h43, 1'b0, Silent},
    '{8'hFF, 1'b0, Predicted}, '{8'hFF, 1'b0, Predicted}, '{8'hFF, 1'b0, Predicted},
    '{8'hFF, 1'b1, Predicted},
    '{8'h66, 1'b0, Silent},   '{8'h4C, 1'b0, Silent},   '{8'h61, 1'b0, Silent},
    '{8'h43, 1'b0, Silent},
    '{8'h00, 1'b0, Predicted}, '{8'h00, 1'b0, Predicted}, '{8'h00, 1'b0, Predicted},
    '{8'h00, 1'b0, Predicted},
    '{8'h7F, 1'b0, Predicted}, '{8'h00, 1'b0, Predicted}, '{8'h00, 1'b0, Predicted},
    '{8'h02, 1'b0, Predicted},
    '{8'hAA, 1'b0, Predicted}, '{8'h55, 1'b1, Predicted}
  };

  localparam int unsigned SrcIdle  [3] = '{30, 71, 0};
  localparam int unsigned SinkIdle [3] = '{71, 30, 0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  event_res_o;
  logic [6:0]  block_type_o;
  logic        is_last_block_o;
  logic [23:0] block_length_o;
  logic        stream_info_valid_o;
  logic [19:0] sample_rate_o;
  logic [3:0]  channel_count_o;
  logic [5:0]  sample_bits_o;
  logic [35:0] total_samples_o;
  logic        last_of_run_o;

  parse_phase_e ph = PhMagic;
  logic [23:0]  pos = '0;
  logic [6:0]   cur_type = '0;
  logic         cur_last = 1'b0;
  logic [23:0]  cur_len = '0;
  logic [63:0]  info = '0;

  parse_result_t expected_q [$];
  int unsigned   src_idle = 0;
  int unsigned   sink_idle = 0;
  int unsigned   parsed_items = 0;
  int unsigned   results_seen = 0;
  int unsigned   info_blocks = 0;
  int unsigned   errors = 0;
  int unsigned   ev_seen [4] = '{0, 0, 0, 0};

  flac_metadata_header_parser u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .end_of_file_i      (end_of_file_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_res_o        (event_res_o),
    .block_type_o       (block_type_o),
    .is_last_block_o    (is_last_block_o),
    .block_length_o     (block_length_o),
    .stream_info_valid_o(stream_info_valid_o),
    .sample_rate_o      (sample_rate_o),
    .channel_count_o    (channel_count_o),
    .sample_bits_o      (sample_bits_o),
    .total_samples_o    (total_samples_o),
    .last_of_run_o      (last_of_run_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle);
  end

  function automatic parse_result_t make_result(event_e ev, logic with_blk, logic valid);
    parse_result_t r;
    logic [31:0]   word;
    r = '0;
    word = info[63:32];
    r.ev = ev;
    if (with_blk) begin
      r.block_type = cur_type;
      r.last_blk = cur_last;
      r.len = cur_len;
    end
    if (valid) begin
      r.info_valid = 1'b1;
      r.rate = word[31:12];
      r.chans = {1'b0, word[11:9]} + 4'd1;
      r.bits = {1'b0, word[8:4]} + 6'd1;
      r.total = {word[3:0], info[31:0]};
    end
    return r;
  endfunction

  // walks one byte through the parser state and returns its results
  function automatic int parse_byte(input logic [7:0] b, input logic e,
                                    output parse_result_t r0, output parse_result_t r1);
    parse_result_t res [2];
    int            n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (ph != PhTail && ph != PhBad) parsed_items++;
    case (ph)
      PhMagic: begin
        if (b != FlacMagic[pos[1:0]]) begin
          res[n++] = make_result(EvBad, 1'b0, 1'b0);
          ph = PhBad;
        end else if (pos >= 24'd3) begin
          ph = PhHeader;
          pos = '0;
        end else begin
          pos++;
          if (e) res[n++] = make_result(EvBad, 1'b0, 1'b0);
        end
      end
      PhHeader: begin
        if (pos == '0) begin
          cur_last = b[7];
          cur_type = b[6:0];
          cur_len = '0;
          info = '0;
        end else begin
          cur_len = {cur_len[15:0], b};
        end
        if (pos >= 24'd3) begin
          res[n++] = make_result(EvHdr, 1'b1, 1'b0);
          if (cur_len == '0) begin
            res[n++] = make_result(EvEnd, 1'b1, 1'b0);
            ph = cur_last ? PhTail : PhHeader;
            pos = '0;
          end else begin
            ph = PhBody;
            pos = '0;
            if (e) res[n++] = make_result(EvTrunc, 1'b1, 1'b0);
          end
        end else begin
          pos++;
          if (e) res[n++] = make_result(EvTrunc, 1'b1, 1'b0);
        end
      end
      PhBody: begin
        if (pos >= InfoFirst && pos <= InfoLast) info = {info[55:0], b};
        if ({1'b0, pos} + 25'd1 >= {1'b0, cur_len}) begin
          res[n++] = make_result(EvEnd, 1'b1, cur_type == '0 && cur_len >= MinInfoLen);
          ph = cur_last ? PhTail : PhHeader;
          pos = '0;
        end else begin
          pos++;
          if (e) res[n++] = make_result(EvTrunc, 1'b1, 1'b0);
        end
      end
      default: ;
    endcase
    if (n > 0) res[n-1].last_of_run = 1'b1;
    if (e) begin
      ph = PhMagic;
      pos = '0;
      cur_type = '0;
      cur_last = 1'b0;
      cur_len = '0;
      info = '0;
    end
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_file_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic e);
    parse_result_t r0, r1;
    int            n;
    n = parse_byte(b, e, r0, r1);
    if (n > 0) expected_q.push_back(r0);
    if (n > 1) expected_q.push_back(r1);
    drive_byte(b, e);
  endtask

  task automatic send_file();
    logic [7:0]  s [$];
    int unsigned kind, nblk, len, keep;
    logic [6:0]  typ;
    logic        huge;
    kind = $urandom_range(99);
    huge = 1'b0;
    if (kind < 10) begin
      repeat ($urandom_range(1, 10)) s.push_back(8'($urandom));
    end else begin
      s = '{8'h66, 8'h4C, 8'h61, 8'h43};
      if (kind < 18) s[$urandom_range(3)] = 8'($urandom);
      nblk = $urandom_range(1, 4);
      for (int unsigned k = 0; k < nblk && !huge; k++) begin
        typ = 7'($urandom);
        case ($urandom_range(11))
          0, 1, 2, 3: begin
            typ = '0;
            len = MinInfoLen + $urandom_range(6);
          end
          4: len = 0;
          5: begin
            huge = 1'b1;
            len = $urandom_range(32'hFF_FFFF);
          end
          default: begin
            if ($urandom_range(2) == 0) typ = '0;
            len = $urandom_range(1, 40);
          end
        endcase
        s.push_back({(k == nblk - 1) || ($urandom_range(15) == 0), typ});
        s.push_back(len[23:16]);
        s.push_back(len[15:8]);
        s.push_back(len[7:0]);
        repeat (huge ? $urandom_range(30) : len) s.push_back(8'($urandom));
      end
      if (!huge) repeat ($urandom_range(3)) s.push_back(8'($urandom));
      if (kind >= 18 && kind < 30) begin
        keep = $urandom_range(1, s.size());
        while (s.size() > keep) void'(s.pop_back());
      end
    end
    foreach (s[i]) send_predicted(s[i], i == s.size() - 1);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction, event_res 0x%0h", event_res_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        ev_seen[want.ev]++;
        if (want.info_valid) info_blocks++;
        check_field("event_res", 64'(want.ev), 64'(event_res_o));
        check_field("block_type", 64'(want.block_type), 64'(block_type_o));
        check_field("is_last_block", 64'(want.last_blk), 64'(is_last_block_o));
        check_field("block_length", 64'(want.len), 64'(block_length_o));
        check_field("stream_info_valid", 64'(want.info_valid), 64'(stream_info_valid_o));
        check_field("sample_rate", 64'(want.rate), 64'(sample_rate_o));
        check_field("channel_count", 64'(want.chans), 64'(channel_count_o));
        check_field("sample_bits", 64'(want.bits), 64'(sample_bits_o));
        check_field("total_samples", 64'(want.total), 64'(total_samples_o));
        check_field("last_of_run", 64'(want.last_of_run), 64'(last_of_run_o));
      end
    end
  end

  initial begin
    #20ms;
    $display("flac_metadata_header_parser regression: fail");
    $finish;
  end

  initial begin : stimulus
    parse_result_t r0, r1, typed;
    int            n;
    int unsigned   target;
    src_idle = SrcIdle[0];
    sink_idle = SinkIdle[0];
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      if (DirRows[i].chk == Predicted) begin
        send_predicted(DirRows[i].data, DirRows[i].eof);
      end else begin
        n = parse_byte(DirRows[i].data, DirRows[i].eof, r0, r1);
        if (DirRows[i].chk == BadMagic) begin
          typed = '0;
          typed.ev = EvBad;
          typed.last_of_run = 1'b1;
          expected_q.push_back(typed);
        end
        drive_byte(DirRows[i].data, DirRows[i].eof);
      end
    end

    for (int p = 0; p < 3; p++) begin
      src_idle = SrcIdle[p];
      sink_idle = SinkIdle[p];
      target = (p + 1) * 340;
      while (parsed_items < target) send_file();
      // hold off until the output side has drained
      in_valid_i <= 1'b0;
      while (expected_q.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end

    repeat (20) @(posedge clk_i);
    $display("checked %0d result transactions from %0d parsed bytes under three stall mixes",
             results_seen, parsed_items);
    $display("bad magic %0d, header %0d, block end %0d (stream info %0d), truncated %0d",
             ev_seen[EvBad], ev_seen[EvHdr], ev_seen[EvEnd], info_blocks, ev_seen[EvTrunc]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("flac_metadata_header_parser regression: pass");
    end else begin
      $display("flac_metadata_header_parser regression: fail");
    end
    $finish;
  end

endmodule
